// ----- design/tsw_pkg.sv -----
// shared types, codes and helpers of the texture sampler
`default_nettype none
package tsw_pkg;

   localparam int MAX_TEXELS_DEF = 65536;
   localparam int COORD_FRAC_DEF = 16;
   localparam int FRAC_MAX_W     = 24;
   localparam int COORD_W        = 24;
   localparam int SIZE_W         = 9;
   localparam int SHIFT_W        = 5;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 9;
   localparam int INDEX_W        = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE   = 3'd4;

   localparam logic       OP_WRITE        = 1'b0;
   localparam logic [1:0] METHOD_NEAREST  = 2'd0;
   localparam logic [1:0] METHOD_BILINEAR = 2'd1;

   localparam logic [1:0] KIND_WRITE    = 2'd0;
   localparam logic [1:0] KIND_NEAREST  = 2'd1;
   localparam logic [1:0] KIND_BILINEAR = 2'd2;
   localparam logic [1:0] KIND_WHITE    = 2'd3;

   typedef struct packed {
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [SHIFT_W-1:0] red_sh;
      logic [SHIFT_W-1:0] green_sh;
      logic [SHIFT_W-1:0] blue_sh;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic                  ok;
      logic [7:0]            r0;
      logic [7:0]            r1;
      logic [7:0]            c0;
      logic [7:0]            c1;
      logic [FRAC_MAX_W-1:0] fr;
      logic [FRAC_MAX_W-1:0] fc;
      logic [31:0]           texel;
   } cmd_type;

   function automatic logic [7:0] chan(input logic [31:0] word, input logic [SHIFT_W-1:0] sh);
      logic [31:0] s;
      s = word >> sh;
      return s[7:0];
   endfunction

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) r = 9'd1;
      else if (v > 9'd256) r = 9'd256;
      else r = v;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/tsw_ram.sv -----
// generic single write, single read ram with registered read
`default_nettype none
module tsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic                                  re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ----- design/tsw_front.sv -----
// front end: takes items, scales and wraps coordinates, issues commands
`default_nettype none
module tsw_front #(
   parameter int COORD_FRAC_BITS = tsw_pkg::COORD_FRAC_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tsw_pkg::cfg_type               cfg,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_operation,
   input  wire logic [7:0]                     req_row,
   input  wire logic [7:0]                     req_col,
   input  wire logic [31:0]                    req_texel,
   input  wire logic [tsw_pkg::COORD_W-1:0]    req_u_coord,
   input  wire logic [tsw_pkg::COORD_W-1:0]    req_v_coord,
   input  wire logic [1:0]                     req_method,
   output tsw_pkg::cmd_type                    cmd,
   output logic                                cmd_push,
   input  wire logic                           cmd_full
);
   import tsw_pkg::*;

   localparam int PROD_W = COORD_W + SIZE_W;
   localparam int INT_W  = PROD_W - COORD_FRAC_BITS;
   localparam int DIGITS = 4;
   localparam int STEPS  = (INT_W + DIGITS - 1) / DIGITS;
   localparam int SHR_W  = STEPS * DIGITS;
   localparam int CNT_W  = $clog2(STEPS + 1);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_MOD  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic                       op_ff;
   logic [7:0]                 row_ff, col_ff;
   logic [31:0]                texel_ff;
   logic [COORD_W-1:0]         u_ff, v_ff;
   logic [1:0]                 method_ff;
   logic [SHR_W-1:0]           qr_ff, qr_in, qc_ff, qc_in;
   logic [SIZE_W-1:0]          remr_ff, remr_in, remc_ff, remc_in;
   logic [COORD_FRAC_BITS-1:0] fr_ff, fc_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [PROD_W-1:0]          ar, ac;
   logic                       accept;

   assign accept   = req_push && !req_full;
   assign req_full = (state_ff != F_IDLE);
   assign ar       = PROD_W'(v_ff) * PROD_W'(cfg.height);
   assign ac       = PROD_W'(u_ff) * PROD_W'(cfg.width);

   // four restoring remainder steps per cycle on both coordinates
   always_comb begin
      logic [SIZE_W:0] tr, tc;
      logic [SIZE_W-1:0] rr, rc;
      rr = remr_ff;
      rc = remc_ff;
      for (int i = 0; i < DIGITS; i++) begin
         tr = {rr, qr_ff[SHR_W-1-i]};
         tc = {rc, qc_ff[SHR_W-1-i]};
         if (tr >= {1'b0, cfg.height}) tr = tr - {1'b0, cfg.height};
         if (tc >= {1'b0, cfg.width}) tc = tc - {1'b0, cfg.width};
         rr = tr[SIZE_W-1:0];
         rc = tc[SIZE_W-1:0];
      end
      remr_in = rr;
      remc_in = rc;
      qr_in   = qr_ff << DIGITS;
      qc_in   = qc_ff << DIGITS;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (accept) state_in = (req_operation == OP_WRITE) ? F_PUSH : F_MUL;
         F_MUL:   state_in = F_MOD;
         F_MOD:   if (cnt_ff == CNT_W'(STEPS - 1)) state_in = F_PUSH;
         F_PUSH:  if (!cmd_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         row_ff    <= req_row;
         col_ff    <= req_col;
         texel_ff  <= req_texel;
         u_ff      <= req_u_coord;
         v_ff      <= req_v_coord;
         method_ff <= req_method;
      end
      if (state_ff == F_MUL) begin
         qr_ff   <= SHR_W'(ar >> COORD_FRAC_BITS);
         qc_ff   <= SHR_W'(ac >> COORD_FRAC_BITS);
         fr_ff   <= ar[COORD_FRAC_BITS-1:0];
         fc_ff   <= ac[COORD_FRAC_BITS-1:0];
         remr_ff <= '0;
         remc_ff <= '0;
         cnt_ff  <= '0;
      end else if (state_ff == F_MOD) begin
         qr_ff   <= qr_in;
         qc_ff   <= qc_in;
         remr_ff <= remr_in;
         remc_ff <= remc_in;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   // neighbour wraps without a second remainder
   always_comb begin
      cmd = '0;
      cmd.texel = texel_ff;
      cmd.fr    = FRAC_MAX_W'(fr_ff);
      cmd.fc    = FRAC_MAX_W'(fc_ff);
      if (op_ff == OP_WRITE) begin
         cmd.kind = KIND_WRITE;
         cmd.r0   = row_ff;
         cmd.c0   = col_ff;
         cmd.ok   = ({1'b0, row_ff} < cfg.height) && ({1'b0, col_ff} < cfg.width);
      end else begin
         case (method_ff)
            METHOD_NEAREST:  cmd.kind = KIND_NEAREST;
            METHOD_BILINEAR: cmd.kind = KIND_BILINEAR;
            default:         cmd.kind = KIND_WHITE;
         endcase
         cmd.r0 = remr_ff[7:0];
         cmd.c0 = remc_ff[7:0];
         cmd.r1 = (remr_ff + 1'b1 == cfg.height) ? 8'd0 : remr_ff[7:0] + 8'd1;
         cmd.c1 = (remc_ff + 1'b1 == cfg.width) ? 8'd0 : remc_ff[7:0] + 8'd1;
      end
   end

   assign cmd_push = (state_ff == F_PUSH) && !cmd_full;
endmodule
`default_nettype wire

// ----- design/tsw_queue.sv -----
// two entry command queue between front and back
`default_nettype none
module tsw_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire tsw_pkg::cmd_type in_cmd,
   output logic                  full,
   input  wire logic             pop,
   output tsw_pkg::cmd_type      out_cmd,
   output logic                  empty
);
   import tsw_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign out_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= in_cmd;
   end
endmodule
`default_nettype wire

// ----- design/tsw_back.sv -----
// back end: texel memory access, blending and the result register
`default_nettype none
module tsw_back #(
   parameter int MAX_TEXELS      = tsw_pkg::MAX_TEXELS_DEF,
   parameter int COORD_FRAC_BITS = tsw_pkg::COORD_FRAC_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tsw_pkg::cfg_type cfg,
   input  wire tsw_pkg::cmd_type cmd,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic                  rsp_write_ok,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue
);
   import tsw_pkg::*;

   localparam int F      = COORD_FRAC_BITS;
   localparam int ADDR_W = MAX_TEXELS > 1 ? $clog2(MAX_TEXELS) : 1;
   localparam int H_W    = F + 8;
   localparam int A_W    = 2 * F + 9;
   localparam logic [A_W-1:0] HALF = A_W'(1) << (2 * F - 1);
   localparam logic [F:0]     ONE  = (F + 1)'(1) << F;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_FETCH = 3'd1;
   localparam logic [2:0] B_DRAIN = 3'd2;
   localparam logic [2:0] B_HORZ  = 3'd3;
   localparam logic [2:0] B_VERT  = 3'd4;
   localparam logic [2:0] B_WRIDX = 3'd5;
   localparam logic [2:0] B_WR    = 3'd6;
   localparam logic [2:0] B_OUT   = 3'd7;

   logic [2:0]         state_ff, state_in;
   cmd_type            cmd_ff;
   logic [1:0]         sel_ff, tag1_ff, tag2_ff;
   logic               pv1_ff, pv2_ff, oob2_ff;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic               oob;
   logic [31:0]        t_ff [4];
   logic [H_W-1:0]     h0_ff [3];
   logic [H_W-1:0]     h1_ff [3];
   logic [7:0]         res_ff [3];
   logic               wok_ff;
   logic               rsp_valid_ff;
   logic [7:0]         out_red_ff, out_green_ff, out_blue_ff;
   logic               out_ok_ff;
   logic [SHIFT_W-1:0] sh [3];
   logic [7:0]         r_sel, c_sel;
   logic               ram_we, ram_re;
   logic [31:0]        ram_rdata;
   logic [1:0]         last_sel;
   logic               out_free;
   logic [F-1:0]       fr, fc;
   logic [F:0]         wr0, wc0;
   logic [H_W-1:0]     h0_in [3];
   logic [H_W-1:0]     h1_in [3];
   logic [7:0]         blend [3];

   assign sh[0] = cfg.red_sh;
   assign sh[1] = cfg.green_sh;
   assign sh[2] = cfg.blue_sh;

   assign r_sel  = sel_ff[1] ? cmd_ff.r1 : cmd_ff.r0;
   assign c_sel  = sel_ff[0] ? cmd_ff.c1 : cmd_ff.c0;
   assign idx_in = INDEX_W'(INDEX_W'(r_sel) * INDEX_W'(cfg.width)) + INDEX_W'(c_sel);
   assign oob    = 32'(idx_ff) >= 32'(MAX_TEXELS);

   assign last_sel = (cmd_ff.kind == KIND_BILINEAR) ? 2'd3 : 2'd0;
   assign out_free = !rsp_valid_ff || rsp_pop;
   assign cmd_pop  = (state_ff == B_IDLE) && !cmd_empty;
   assign ram_re   = pv1_ff && !oob;
   assign ram_we   = (state_ff == B_WR) && cmd_ff.ok && !oob;

   tsw_ram #(.WIDTH(32), .DEPTH(MAX_TEXELS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(idx_ff)),
      .wdata (cmd_ff.texel),
      .re    (ram_re),
      .raddr (ADDR_W'(idx_ff)),
      .rdata (ram_rdata)
   );

   assign fr  = cmd_ff.fr[F-1:0];
   assign fc  = cmd_ff.fc[F-1:0];
   assign wr0 = ONE - {1'b0, fr};
   assign wc0 = ONE - {1'b0, fc};

   // horizontal then vertical blend per channel, exact in integers
   always_comb begin
      logic [A_W-1:0] acc;
      logic [A_W-1:0] val;
      for (int k = 0; k < 3; k++) begin
         h0_in[k] = H_W'((F + 9)'(wc0) * (F + 9)'(chan(t_ff[0], sh[k])))
                  + H_W'((F + 9)'(fc) * (F + 9)'(chan(t_ff[1], sh[k])));
         h1_in[k] = H_W'((F + 9)'(wc0) * (F + 9)'(chan(t_ff[2], sh[k])))
                  + H_W'((F + 9)'(fc) * (F + 9)'(chan(t_ff[3], sh[k])));
         acc = A_W'(A_W'(wr0) * A_W'(h0_ff[k])) + A_W'(A_W'(fr) * A_W'(h1_ff[k])) + HALF;
         val = acc >> (2 * F);
         blend[k] = (val > A_W'(255)) ? 8'd255 : val[7:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               case (cmd.kind)
                  KIND_WRITE:  state_in = B_WRIDX;
                  KIND_WHITE:  state_in = B_OUT;
                  default:     state_in = B_FETCH;
               endcase
            end
         end
         B_FETCH: if (sel_ff == last_sel) state_in = B_DRAIN;
         B_DRAIN: if (!pv1_ff && !pv2_ff) state_in = B_HORZ;
         B_HORZ:  state_in = (cmd_ff.kind == KIND_BILINEAR) ? B_VERT : B_OUT;
         B_VERT:  state_in = B_OUT;
         B_WRIDX: state_in = B_WR;
         B_WR:    state_in = B_OUT;
         B_OUT:   if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         pv1_ff       <= 1'b0;
         pv2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv1_ff   <= (state_ff == B_FETCH);
         pv2_ff   <= pv1_ff;
         if (state_ff == B_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_pop) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd;
         sel_ff <= 2'd0;
         wok_ff <= 1'b0;
         for (int k = 0; k < 3; k++) res_ff[k] <= (cmd.kind == KIND_WHITE) ? 8'd255 : 8'd0;
      end
      if (state_ff == B_FETCH) sel_ff <= sel_ff + 2'd1;
      if (state_ff == B_FETCH || state_ff == B_WRIDX) idx_ff <= idx_in;
      tag1_ff <= sel_ff;
      tag2_ff <= tag1_ff;
      oob2_ff <= oob;
      if (pv2_ff) t_ff[tag2_ff] <= oob2_ff ? 32'd0 : ram_rdata;
      if (state_ff == B_HORZ) begin
         for (int k = 0; k < 3; k++) begin
            h0_ff[k]  <= h0_in[k];
            h1_ff[k]  <= h1_in[k];
            res_ff[k] <= chan(t_ff[0], sh[k]);
         end
      end
      if (state_ff == B_VERT) begin
         for (int k = 0; k < 3; k++) res_ff[k] <= blend[k];
      end
      if (state_ff == B_WR) wok_ff <= cmd_ff.ok && !oob;
      if (state_ff == B_OUT && out_free) begin
         out_ok_ff    <= wok_ff;
         out_red_ff   <= res_ff[0];
         out_green_ff <= res_ff[1];
         out_blue_ff  <= res_ff[2];
      end
   end

   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_write_ok = out_ok_ff;
   assign rsp_red      = out_red_ff;
   assign rsp_green    = out_green_ff;
   assign rsp_blue     = out_blue_ff;
endmodule
`default_nettype wire

// ----- design/texture_sampler_wrap_top.sv -----
// top level of the wrapping texture sampler
//
//  channel  direction  handshake           beat carries
//  req      in         push / full         operation, row, col, texel, u, v, method
//  rsp      out        pop / empty         write_ok, red, green, blue
//  csr      in         we (no wait)        index, 9-bit data
//
//  the front wrap unit works by restoring remainder steps and the back reads one
//  texel a cycle from the texel ram, which has a write port and a read port
//  reset is synchronous and active high; the texel ram is not cleared
//  front and back each stall on their own around a two-beat command queue,
//  and one finished beat waits in the result register while the next is worked
`default_nettype none
module texture_sampler_wrap_top #(
   parameter int MAX_TEXELS      = tsw_pkg::MAX_TEXELS_DEF,
   parameter int COORD_FRAC_BITS = tsw_pkg::COORD_FRAC_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_operation,
   input  wire logic [7:0]                     req_row,
   input  wire logic [7:0]                     req_col,
   input  wire logic [31:0]                    req_texel,
   input  wire logic [tsw_pkg::COORD_W-1:0]    req_u_coord,
   input  wire logic [tsw_pkg::COORD_W-1:0]    req_v_coord,
   input  wire logic [1:0]                     req_method,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic                                rsp_write_ok,
   output logic [7:0]                          rsp_red,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_blue,
   input  wire logic                           csr_we,
   input  wire logic [tsw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tsw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tsw_pkg::*;

   // raw register copies, sizes are clamped on the way out
   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [SHIFT_W-1:0] red_sh_ff, green_sh_ff, blue_sh_ff;
   cfg_type            cfg;
   cmd_type            front_cmd, queue_cmd;
   logic               front_push, queue_full, queue_empty, back_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 9'd1;
         height_ff   <= 9'd1;
         red_sh_ff   <= 5'd0;
         green_sh_ff <= 5'd8;
         blue_sh_ff  <= 5'd16;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff    <= csr_wdata;
            CSR_HEIGHT: height_ff   <= csr_wdata;
            CSR_RED:    red_sh_ff   <= csr_wdata[SHIFT_W-1:0];
            CSR_GREEN:  green_sh_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_BLUE:   blue_sh_ff  <= csr_wdata[SHIFT_W-1:0];
            default:    ;
         endcase
      end
   end

   // zero acts as one, anything above 256 as 256
   assign cfg.width    = eff_size(width_ff);
   assign cfg.height   = eff_size(height_ff);
   assign cfg.red_sh   = red_sh_ff;
   assign cfg.green_sh = green_sh_ff;
   assign cfg.blue_sh  = blue_sh_ff;

   tsw_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_texel     (req_texel),
      .req_u_coord   (req_u_coord),
      .req_v_coord   (req_v_coord),
      .req_method    (req_method),
      .cmd           (front_cmd),
      .cmd_push      (front_push),
      .cmd_full      (queue_full)
   );

   tsw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .in_cmd  (front_cmd),
      .full    (queue_full),
      .pop     (back_pop),
      .out_cmd (queue_cmd),
      .empty   (queue_empty)
   );

   tsw_back #(.MAX_TEXELS(MAX_TEXELS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (queue_cmd),
      .cmd_empty    (queue_empty),
      .cmd_pop      (back_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_write_ok (rsp_write_ok),
      .rsp_red      (rsp_red),
      .rsp_green    (rsp_green),
      .rsp_blue     (rsp_blue)
   );
endmodule
`default_nettype wire

// ----- design/tsw_checker.sv -----
// port level checks of the texture sampler and their bind
`default_nettype none
module tsw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_push,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic       rsp_write_ok,
   input wire logic [7:0] rsp_red,
   input wire logic [7:0] rsp_green,
   input wire logic [7:0] rsp_blue
);
   // nothing waits on the result side straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // a waiting result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_write_ok) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("result beat changed while stalled");

   // a successful write reports black
   a_write_black: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_write_ok |-> rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0)
      else $error("write result carries colour");

   // the front holds one item at a time
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |=> req_full)
      else $error("front took a second item while busy");
endmodule

bind texture_sampler_wrap_top tsw_checker u_tsw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_push     (req_push),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_write_ok (rsp_write_ok),
   .rsp_red      (rsp_red),
   .rsp_green    (rsp_green),
   .rsp_blue     (rsp_blue)
);
`default_nettype wire
